// ----- rtl/ffac_pkg.sv -----
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared types and constants of the first-fit allocator with coalescing.
// ----------------------------------------------------------------------------
`default_nettype none

package ffac_pkg;

  // memory geometry
  localparam int Units = 64;
  localparam int IdxW  = $clog2(Units);
  localparam int LenW  = $clog2(Units + 1);
  localparam int OwnW  = 3;
  localparam int SizeW = 7;

  // command codes
  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    StGranted = 2'd0,
    StNoFit   = 2'd1,
    StFreed   = 2'd2,
    StBadFree = 2'd3
  } status_e;

  // controller states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StCommit
  } state_e;

  // contents of one memory cell
  typedef struct packed {
    logic            free;
    logic [OwnW-1:0] owner;
    logic            head;
  } cell_t;

  // parallel update broadcast to every cell
  typedef struct packed {
    logic            alloc_en;
    logic            free_en;
    logic [LenW-1:0] lo;
    logic [LenW-1:0] hi;
    logic [OwnW-1:0] owner;
    logic            clr_lo;
    logic            clr_hi;
  } commit_t;

endpackage

`default_nettype wire

// ----- rtl/ffac_req_if.sv -----
// ----------------------------------------------------------------------------
// ffac_req_if
// Command channel: valid/ready handshake with allocate and free payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffac_req_if;
  logic                            valid;
  logic                            ready;
  ffac_pkg::cmd_e                  command;
  logic [ffac_pkg::OwnW-1:0]       requester;
  logic [ffac_pkg::SizeW-1:0]      request_size;
  logic [ffac_pkg::IdxW-1:0]       free_start;

  modport source (output valid, command, requester, request_size, free_start,
                  input ready);
  modport sink   (input valid, command, requester, request_size, free_start,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/ffac_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ffac_rsp_if
// Result channel: valid/ready handshake with status and start index.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffac_rsp_if;
  logic                       valid;
  logic                       ready;
  ffac_pkg::status_e          status;
  logic [ffac_pkg::IdxW-1:0]  start_index;

  modport source (output valid, status, start_index, input ready);
  modport sink   (input valid, status, start_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/ffac_cell.sv -----
// ----------------------------------------------------------------------------
// ffac_cell
// One memory cell of the ring: passes its contents on while scanning and
// applies the broadcast allocate or free update against its own index.
// ----------------------------------------------------------------------------
`default_nettype none

module ffac_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ffac_pkg::IdxW-1:0] idx_i,
  input  wire logic                      shift_en_i,
  input  wire ffac_pkg::cell_t           next_i,
  input  wire ffac_pkg::commit_t         commit_i,
  output      ffac_pkg::cell_t           cell_o
);

  ffac_pkg::cell_t cell_d, cell_q;
  logic [ffac_pkg::LenW-1:0] idx_w;
  logic in_range, at_lo, at_hi;

  // position of this cell against the update range
  assign idx_w    = {1'b0, idx_i};
  assign in_range = (idx_w >= commit_i.lo) && (idx_w < commit_i.hi);
  assign at_lo    = (idx_w == commit_i.lo);
  assign at_hi    = (idx_w == commit_i.hi);

  // next contents
  always_comb begin
    cell_d = cell_q;
    if (shift_en_i) begin
      cell_d = next_i;
    end else if (commit_i.alloc_en) begin
      if (in_range) begin
        cell_d.free  = 1'b0;
        cell_d.owner = commit_i.owner;
      end
      if (at_hi) begin
        cell_d.head = 1'b1;
      end
    end else if (commit_i.free_en) begin
      if (in_range) begin
        cell_d.free  = 1'b1;
        cell_d.owner = '0;
      end
      if ((at_lo && commit_i.clr_lo) || (at_hi && commit_i.clr_hi)) begin
        cell_d.head = 1'b0;
      end
    end
  end

  // cell register, reset to a free cell, head only at cell zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q.free  <= 1'b1;
      cell_q.owner <= '0;
      cell_q.head  <= (idx_i == '0);
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

`default_nettype wire

// ----- rtl/ffac_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffac_ctrl
// Scan controller: watches the cell passing position zero during one full
// rotation of the ring, then issues the update and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ffac_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  ffac_req_if.sink                 req_i,
  ffac_rsp_if.source               rsp_o,
  input  wire ffac_pkg::cell_t     scan_cell_i,
  output      logic                shift_en_o,
  output      ffac_pkg::commit_t   commit_o
);

  localparam int IdxW = ffac_pkg::IdxW;
  localparam int LenW = ffac_pkg::LenW;

  ffac_pkg::state_e state_d, state_q;
  logic [IdxW-1:0]  t_d, t_q;

  // captured command
  ffac_pkg::cmd_e              cmd_q;
  logic [ffac_pkg::OwnW-1:0]   owner_q;
  logic [ffac_pkg::SizeW-1:0]  size_q;
  logic [IdxW-1:0]             fs_q;

  // allocate scan state
  logic [IdxW-1:0] seg_start_d, seg_start_q;
  logic            seg_free_d, seg_free_q;
  logic            found_d, found_q;
  logic [IdxW-1:0] pos_d, pos_q;

  // free scan state
  logic            prev_free_d, prev_free_q;
  logic            head_ok_d, head_ok_q;
  logic            e_found_d, e_found_q;
  logic [IdxW-1:0] e_d, e_q;
  logic            e_free_d, e_free_q;

  // result register
  logic                   out_valid_d, out_valid_q;
  ffac_pkg::status_e      status_d, status_q;
  logic [IdxW-1:0]        start_d, start_q;

  logic            accept, slot_free, go;
  logic [LenW-1:0] run_len, last_len, end_pos;
  logic            grant;
  logic [IdxW-1:0] gpos;

  assign slot_free    = !out_valid_q || rsp_o.ready;
  assign req_i.ready  = (state_q == ffac_pkg::StIdle);
  assign accept       = req_i.valid && req_i.ready;
  assign go           = (state_q == ffac_pkg::StCommit) && slot_free;
  assign shift_en_o   = (state_q == ffac_pkg::StScan);

  // length of the segment closed by the current head, and of the last one
  assign run_len  = {1'b0, t_q} - {1'b0, seg_start_q};
  assign last_len = LenW'(ffac_pkg::Units) - {1'b0, seg_start_q};
  assign end_pos  = e_found_q ? {1'b0, e_q} : LenW'(ffac_pkg::Units);

  // first-fit decision including the segment that runs to the end
  assign grant = (size_q != '0) &&
                 (found_q || (seg_free_q && (last_len >= size_q)));
  assign gpos  = found_q ? pos_q : seg_start_q;

  // state machine and scan bookkeeping
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    seg_start_d = seg_start_q;
    seg_free_d  = seg_free_q;
    found_d     = found_q;
    pos_d       = pos_q;
    prev_free_d = prev_free_q;
    head_ok_d   = head_ok_q;
    e_found_d   = e_found_q;
    e_d         = e_q;
    e_free_d    = e_free_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    start_d     = start_q;
    commit_o    = '0;

    unique case (state_q)
      ffac_pkg::StIdle: begin
        if (accept) begin
          state_d     = ffac_pkg::StScan;
          t_d         = '0;
          seg_start_d = '0;
          seg_free_d  = 1'b0;
          found_d     = 1'b0;
          pos_d       = '0;
          prev_free_d = 1'b0;
          head_ok_d   = 1'b0;
          e_found_d   = 1'b0;
          e_d         = '0;
          e_free_d    = 1'b0;
        end
      end
      ffac_pkg::StScan: begin
        // allocate: close a segment at each head
        if (scan_cell_i.head) begin
          if ((t_q != '0) && !found_q && seg_free_q &&
              (run_len >= size_q)) begin
            found_d = 1'b1;
            pos_d   = seg_start_q;
          end
          seg_start_d = t_q;
          seg_free_d  = scan_cell_i.free;
        end
        // free: neighbours and end of the released segment
        if ((fs_q != '0) && (t_q == fs_q - IdxW'(1))) begin
          prev_free_d = scan_cell_i.free;
        end
        if (t_q == fs_q) begin
          head_ok_d = scan_cell_i.head && !scan_cell_i.free;
        end
        if ((t_q > fs_q) && scan_cell_i.head && !e_found_q) begin
          e_found_d = 1'b1;
          e_d       = t_q;
          e_free_d  = scan_cell_i.free;
        end
        t_d = t_q + IdxW'(1);
        if (t_q == IdxW'(ffac_pkg::Units - 1)) begin
          state_d = ffac_pkg::StCommit;
        end
      end
      ffac_pkg::StCommit: begin
        if (go) begin
          state_d     = ffac_pkg::StIdle;
          out_valid_d = 1'b1;
          start_d     = '0;
          if (cmd_q == ffac_pkg::CmdAlloc) begin
            commit_o.alloc_en = grant;
            commit_o.lo       = {1'b0, gpos};
            commit_o.hi       = {1'b0, gpos} + LenW'(size_q);
            commit_o.owner    = owner_q;
            status_d          = grant ? ffac_pkg::StGranted : ffac_pkg::StNoFit;
            start_d           = grant ? gpos : '0;
          end else begin
            commit_o.free_en = head_ok_q;
            commit_o.lo      = {1'b0, fs_q};
            commit_o.hi      = end_pos;
            commit_o.clr_lo  = (fs_q != '0) && prev_free_q;
            commit_o.clr_hi  = e_found_q && e_free_q;
            status_d         = head_ok_q ? ffac_pkg::StFreed : ffac_pkg::StBadFree;
          end
        end
      end
      default: state_d = ffac_pkg::StIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffac_pkg::StIdle;
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_i.command;
      owner_q <= req_i.requester;
      size_q  <= req_i.request_size;
      fs_q    <= req_i.free_start;
    end
    seg_start_q <= seg_start_d;
    seg_free_q  <= seg_free_d;
    found_q     <= found_d;
    pos_q       <= pos_d;
    prev_free_q <= prev_free_d;
    head_ok_q   <= head_ok_d;
    e_found_q   <= e_found_d;
    e_q         <= e_d;
    e_free_q    <= e_free_d;
    status_q    <= status_d;
    start_q     <= start_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.start_index = start_q;

endmodule

`default_nettype wire

// ----- rtl/first_fit_allocator_coalescing_core.sv -----
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_core
// First-fit segment allocator over a ring of memory cells with coalescing.
// ----------------------------------------------------------------------------
// Each command goes from acceptance to result in two steps: the cell ring makes
// one full rotation past the scan controller, and then the commit state applies
// the update to every cell in parallel while the result is registered.
// One command is in flight at a time; a new command is accepted in the cycle
// after the update has been applied, even while the previous result waits to
// be taken. A result that is not taken holds the next command's update back
// until the result slot is free. Allocation grants the lowest-addressed free
// segment large enough; freeing merges the released segment with free
// neighbours on either side.
`default_nettype none

module first_fit_allocator_coalescing_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ffac_req_if.sink   req_i,
  ffac_rsp_if.source rsp_o
);

  localparam int Units = ffac_pkg::Units;

  ffac_pkg::cell_t   cells [Units];
  ffac_pkg::commit_t commit;
  logic              shift_en;

  // scan controller
  ffac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .scan_cell_i (cells[0]),
    .shift_en_o  (shift_en),
    .commit_o    (commit)
  );

  // ring of cells, each taking its upper neighbour's contents when shifting
  for (genvar k = 0; k < Units; k++) begin : g_cell
    ffac_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (ffac_pkg::IdxW'(k)),
      .shift_en_i (shift_en),
      .next_i     (cells[(k + 1) % Units]),
      .commit_i   (commit),
      .cell_o     (cells[k])
    );
  end

`ifndef SYNTHESIS
  // cell zero heads a segment whenever the ring is at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !shift_en |-> cells[0].head)
    else $error("cell zero lost its segment head");

  // an update never allocates and frees at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(commit.alloc_en && commit.free_en))
    else $error("allocate and free updates together");

  // no update while the ring rotates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_en |-> !(commit.alloc_en || commit.free_en))
    else $error("update during rotation");

  // start index is zero unless granted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && (rsp_o.status != ffac_pkg::StGranted)) |->
      (rsp_o.start_index == '0))
    else $error("start index set on a non-granted result");
`endif

endmodule

`default_nettype wire
